// ===== hw/rtl/htrie_pkg.sv =====
`default_nettype none

package htrie_pkg;

  // sizes of the trie and its transition table
  localparam int MaxNodes    = 1024;
  localparam int HashBuckets = 1365;
  localparam int NodeW       = 10;   // node number
  localparam int CntW        = 11;   // node count, limit, chain link
  localparam int BucketW     = 11;   // bucket index
  localparam int SymW        = 8;    // letter
  localparam int HashW       = 16;   // letter*11 + node*53 before reduction
  localparam int LetterMul   = 11;
  localparam int NodeMul     = 53;
  localparam int ModSteps    = 6;    // conditional subtracts of HashBuckets << 5 .. << 0
  localparam int StepW       = 3;

  // result status, also used as the per-word fault code (taken == no fault)
  typedef enum logic [1:0] {
    STAT_TAKEN  = 2'd0,
    STAT_DONE   = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  // register index taken from paddr[2]
  localparam logic RegNodeLimit = 1'b0;

  // one stored transition, kept at the index of the child node
  typedef struct packed {
    logic [NodeW-1:0] from;
    logic [SymW-1:0]  sym;
    logic [CntW-1:0]  link;
  } edge_t;

endpackage

`default_nettype wire

// ===== hw/rtl/htrie_hash.sv =====
`default_nettype none

// Bucket of a transition: (letter*11 + node*53) mod HashBuckets.
// One compare/subtract unit, reused for each of the ModSteps reduction steps.
module htrie_hash (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [htrie_pkg::NodeW-1:0]     node_i,
  input  logic [htrie_pkg::SymW-1:0]      letter_i,
  output logic                            done_o,
  output logic [htrie_pkg::BucketW-1:0]   bucket_o
);
  import htrie_pkg::*;

  logic [HashW-1:0] acc_q;
  logic [HashW-1:0] sum;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;
  logic [HashW:0]   sub;

  assign sum = HashW'(HashW'(letter_i) * HashW'(LetterMul))
             + HashW'(HashW'(node_i) * HashW'(NodeMul));
  assign sub = (HashW+1)'(HashBuckets) << step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepW'(ModSteps - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= sum;
    end else if (busy_q && ({1'b0, acc_q} >= sub)) begin
      acc_q <= acc_q - sub[HashW-1:0];
    end
  end

  assign done_o   = done_q;
  assign bucket_o = acc_q[BucketW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/hashed_trie_insert_lookup.sv =====
`default_nettype none

// Trie of words held as a chained hash table of transitions. Words come in one
// letter per item, each item tagged insert or lookup; every item returns one
// result (status and the node reached). The transition (node, letter) hashes to
// bucket (letter*11 + node*53) mod 1365; each bucket heads a chain of edges kept
// in a 1024-entry edge memory at the index of the child node. A letter runs the
// subtract unit through its 6 reduction steps and then signals done, then reads
// the bucket head, reads each chain entry until the match or the chain's end,
// allocates or faults when the transition is missing, reads the final mark,
// loads the output register and goes back to idle. An item with the word
// already faulted, or an empty word, skips the walk: mark read, output load
// and idle. A result held by the receiver stalls the output load. One item is
// in flight at a time; the next is accepted as soon as the result is in the
// output register. After reset a clearing pass zeroes the bucket heads and
// final marks; no item is accepted during it, register writes are. node_limit
// (paddr 0) caps the nodes allocated, root included; values above 1024 act as
// 1024.
module hashed_trie_insert_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [htrie_pkg::SymW-1:0]    letter_i,
  input  logic                          last_i,
  input  logic                          empty_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [htrie_pkg::NodeW-1:0]   node_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import htrie_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,   // zero bucket heads and final marks
    ST_IDLE,
    ST_HASH,    // bucket reduction running
    ST_HEAD,    // bucket head data back
    ST_CHAIN,   // chain entry data back
    ST_MISS,    // no transition: allocate or fault
    ST_MARK,    // final mark read
    ST_FINISH   // load the output register
  } state_e;

  state_e             state_q;
  logic [BucketW-1:0] clr_q;
  logic [NodeW-1:0]   walk_q;
  status_e            fault_q;
  logic [CntW-1:0]    nodes_used_q;
  logic [CntW-1:0]    node_limit_q;
  logic               out_valid_q;

  // item payload
  action_e            act_q;
  logic [SymW-1:0]    sym_q;
  logic               ends_q;
  logic [CntW-1:0]    head_q;
  logic [NodeW-1:0]   cur_q;
  status_e            status_q;
  status_e            status_d;
  logic [NodeW-1:0]   node_q;

  // memories and their read registers
  logic [CntW-1:0]    head_mem [HashBuckets];
  logic               mark_mem [MaxNodes];
  edge_t              edge_mem [MaxNodes];
  logic [CntW-1:0]    head_rd_q;
  logic               mark_rd_q;
  edge_t              edge_rd_q;

  logic               accept;
  logic               hash_start;
  logic               hash_done;
  logic [BucketW-1:0] bucket;
  logic [CntW-1:0]    lim;
  logic               hit;
  logic               alloc;
  logic               finish_go;
  logic               cfg_we;
  logic               head_re;
  logic               head_we;
  logic [BucketW-1:0] head_waddr;
  logic [CntW-1:0]    head_wdata;
  logic               edge_re;
  logic [NodeW-1:0]   edge_raddr;
  logic               mark_we;
  logic [NodeW-1:0]   mark_waddr;
  logic               mark_wdata;
  logic [NodeW-1:0]   fresh;

  htrie_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .node_i   (walk_q),
    .letter_i (letter_i),
    .done_o   (hash_done),
    .bucket_o (bucket)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == RegNodeLimit);
  assign prdata = (paddr[2] == RegNodeLimit) ? {{(32-CntW){1'b0}}, node_limit_q} : '0;

  assign lim = (node_limit_q > CntW'(MaxNodes)) ? CntW'(MaxNodes) : node_limit_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  // a faulted word or an empty word skips the walk
  assign hash_start = accept && (fault_q == STAT_TAKEN) && !empty_word_i;

  assign fresh     = nodes_used_q[NodeW-1:0];
  assign hit       = (edge_rd_q.from == walk_q) && (edge_rd_q.sym == sym_q);
  assign alloc     = (state_q == ST_MISS) && (act_q == ACT_INSERT) && (nodes_used_q < lim);
  assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign head_re   = (state_q == ST_HASH) && hash_done;

  always_comb begin
    edge_re    = 1'b0;
    edge_raddr = edge_rd_q.link[NodeW-1:0];
    if (state_q == ST_HEAD) begin
      edge_re    = (head_rd_q != '0);
      edge_raddr = head_rd_q[NodeW-1:0];
    end else if (state_q == ST_CHAIN) begin
      edge_re    = !hit && (edge_rd_q.link != '0);
    end
  end

  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = CntW'(fresh);
    if (state_q == ST_CLEAR) begin
      head_we    = 1'b1;
      head_waddr = clr_q;
      head_wdata = '0;
    end else if (alloc) begin
      head_we    = 1'b1;
    end
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = walk_q;
    mark_wdata = 1'b1;
    if (state_q == ST_CLEAR) begin
      mark_we    = (clr_q < BucketW'(MaxNodes));
      mark_waddr = clr_q[NodeW-1:0];
      mark_wdata = 1'b0;
    end else if (finish_go && (fault_q == STAT_TAKEN) && ends_q && (act_q == ACT_INSERT)) begin
      mark_we    = 1'b1;
    end
  end

  // result of this item
  always_comb begin
    if (fault_q != STAT_TAKEN) begin
      status_d = fault_q;
    end else if (!ends_q) begin
      status_d = STAT_TAKEN;
    end else if (act_q == ACT_LOOKUP) begin
      status_d = mark_rd_q ? STAT_DONE : STAT_ABSENT;
    end else begin
      status_d = STAT_DONE;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      walk_q       <= '0;
      fault_q      <= STAT_TAKEN;
      nodes_used_q <= CntW'(1);
      node_limit_q <= CntW'(MaxNodes);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_limit_q <= pwdata[CntW-1:0];
      end
      // result held until taken; a new one loads as the old one leaves
      out_valid_q <= finish_go | (out_valid_q & ~out_ready_i);
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BucketW'(HashBuckets - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= hash_start ? ST_HASH : ST_MARK;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            state_q <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          state_q <= (head_rd_q == '0) ? ST_MISS : ST_CHAIN;
        end
        ST_CHAIN: begin
          if (hit) begin
            walk_q  <= cur_q;
            state_q <= ST_MARK;
          end else if (edge_rd_q.link == '0) begin
            state_q <= ST_MISS;
          end
        end
        ST_MISS: begin
          if (act_q == ACT_LOOKUP) begin
            fault_q <= STAT_ABSENT;
          end else if (alloc) begin
            nodes_used_q <= nodes_used_q + 1'b1;
            walk_q       <= fresh;
          end else begin
            fault_q <= STAT_FULL;
          end
          state_q <= ST_MARK;
        end
        ST_MARK: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_go) begin
            if (ends_q) begin
              walk_q  <= '0;
              fault_q <= STAT_TAKEN;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // item payload and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_e'(action_i);
      sym_q  <= letter_i;
      ends_q <= last_i | empty_word_i;
    end
    if (state_q == ST_HEAD) begin
      head_q <= head_rd_q;
      cur_q  <= head_rd_q[NodeW-1:0];
    end else if ((state_q == ST_CHAIN) && edge_re) begin
      cur_q  <= edge_rd_q.link[NodeW-1:0];
    end
    if (finish_go) begin
      status_q <= status_d;
      node_q   <= walk_q;
    end
  end

  // bucket heads
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd_q <= head_mem[bucket];
    end
  end

  // transitions
  always_ff @(posedge clk_i) begin
    if (alloc) begin
      edge_mem[fresh] <= '{from: walk_q, sym: sym_q, link: head_q};
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[edge_raddr];
    end
  end

  // final marks
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (state_q == ST_MARK) begin
      mark_rd_q <= mark_mem[walk_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign node_o      = node_q;

`ifndef SYNTH
  a_nodes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nodes_used_q >= CntW'(1)) && (nodes_used_q <= CntW'(MaxNodes)))
    else $error("node count out of range");

  a_walk_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(walk_q) < nodes_used_q)
    else $error("walk node not allocated");

  a_nodes_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(nodes_used_q) |-> (nodes_used_q == $past(nodes_used_q) + 1'b1)
      && ($past(state_q) == ST_MISS))
    else $error("node count moved outside allocation");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (bucket < BucketW'(HashBuckets)))
    else $error("bucket out of range");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_FINISH))
    else $error("result loaded outside finish");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import htrie_pkg::*;

  // run limits
  localparam int CycleLimit = 400000;  // far above the slowest correct run
  localparam int LongHold   = 400;     // receiver hold-off that backs up the block
  localparam int DrainWait  = 60;      // a letter walk plus a long chain
  localparam int DictDepth  = 256;
  localparam int MaxWordLen = 8;

  // one input item and one result item
  typedef struct packed {
    action_e    act;
    logic [7:0] sym;
    logic       last;
    logic       is_empty;
  } letter_item_t;

  typedef struct packed {
    status_e          status;
    logic [NodeW-1:0] node;
  } trie_answer_t;

  // dut ports
  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              action_i;
  logic [SymW-1:0]   letter_i;
  logic              last_i;
  logic              empty_word_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        status_o;
  logic [NodeW-1:0]  node_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // trie mirror: final marks, chain heads and edges kept at the child index
  bit          trie_final [MaxNodes];
  int          chain_head [HashBuckets];
  int          edge_from  [MaxNodes];
  int          edge_sym   [MaxNodes];
  int          edge_next  [MaxNodes];
  int          trie_nodes;     // nodes allocated, root included
  int          cursor;         // node the current word has reached
  status_e     word_err;       // fault of the current word, TAKEN when none
  int          limit_reg;      // node_limit as written

  // stimulus and scoreboard
  letter_item_t letters_q [$];
  trie_answer_t answers_q [$];
  letter_item_t next_item;
  trie_answer_t seen;
  trie_answer_t want;
  bit          in_taken;
  int          send_gap;
  int          recv_gap;
  int          hold_left;
  int          send_odds;      // percent chance of a sender burst per item
  int          recv_odds;      // percent chance of a receiver burst per cycle
  int          stall_asked;
  int          stall_served;
  int          errors;
  int          cycle_count;
  int          items_queued;
  int          answers_checked;
  int          full_seen;
  int          absent_seen;

  // word scratch and the dictionary of inserted words
  logic [7:0]  wbuf [MaxWordLen];
  int          wlen;
  logic [7:0]  dict_sym [DictDepth][MaxWordLen];
  int          dict_len [DictDepth];
  int          dict_count;

  hashed_trie_insert_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .letter_i     (letter_i),
    .last_i       (last_i),
    .empty_word_i (empty_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .node_o       (node_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Walk one item through the mirror trie and return the answer it must give.
  // Missing edge: lookup faults absent, insert allocates or faults full.
  // Once faulted, the rest of the word just repeats the fault.
  function automatic trie_answer_t walk_trie(letter_item_t it);
    int           lim;
    int           bucket;
    int           cur;
    int           steps;
    int           child;
    logic         ends;
    trie_answer_t r;
    ends = it.last | it.is_empty;
    lim = (limit_reg > MaxNodes) ? MaxNodes : limit_reg;
    if (word_err == STAT_TAKEN && !it.is_empty) begin
      bucket = (int'(it.sym) * LetterMul + cursor * NodeMul) % HashBuckets;
      cur = chain_head[bucket];
      steps = 0;
      child = 0;
      while (cur != 0 && cur < MaxNodes && steps < MaxNodes && child == 0) begin
        if (edge_from[cur] == cursor && edge_sym[cur] == int'(it.sym)) begin
          child = cur;
        end else begin
          cur = edge_next[cur];
        end
        steps++;
      end
      if (child != 0) begin
        cursor = child;
      end else if (it.act == ACT_LOOKUP) begin
        word_err = STAT_ABSENT;
      end else if (trie_nodes >= lim) begin
        word_err = STAT_FULL;
      end else begin
        // new edge goes to the head of its chain
        edge_from[trie_nodes] = cursor;
        edge_sym[trie_nodes]  = int'(it.sym);
        edge_next[trie_nodes] = chain_head[bucket];
        chain_head[bucket]    = trie_nodes;
        cursor = trie_nodes;
        trie_nodes++;
      end
    end
    if (word_err != STAT_TAKEN) begin
      r.status = word_err;
    end else if (ends) begin
      if (it.act == ACT_LOOKUP) begin
        r.status = trie_final[cursor] ? STAT_DONE : STAT_ABSENT;
      end else begin
        trie_final[cursor] = 1'b1;
        r.status = STAT_DONE;
      end
    end else begin
      r.status = STAT_TAKEN;
    end
    r.node = cursor[NodeW-1:0];
    if (ends) begin
      cursor = 0;
      word_err = STAT_TAKEN;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: inputs move on the falling edge. A new item is offered once the
  // previous one was taken; random gaps sometimes sit between items.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (letters_q.size() > 0) begin
          next_item = letters_q.pop_front();
          action_i     <= next_item.act;
          letter_i     <= next_item.sym;
          last_i       <= next_item.last;
          empty_word_i <= next_item.is_empty;
          in_valid_i   <= 1'b1;
          if (send_odds > 0 && $urandom_range(1, 100) <= send_odds) begin
            send_gap = $urandom_range(1, 13);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold-off on request so the
  // output register fills and in_ready drops while items keep coming.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_served != stall_asked) begin
        stall_served = stall_asked;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (recv_odds > 0 && $urandom_range(1, 100) <= recv_odds) begin
          recv_gap = $urandom_range(1, 13);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on the rising edge, predict each accepted item, then check each
  // accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        answers_q.push_back(walk_trie(letter_item_t'{
          act: action_e'(action_i), sym: letter_i, last: last_i, is_empty: empty_word_i}));
      end
      if (out_valid_o && out_ready_i) begin
        seen.status = status_e'(status_o);
        seen.node   = node_o;
        if (answers_q.size() == 0) begin
          $error("result with none expected: status %0d node %0d", status_o, node_o);
          errors++;
        end else begin
          want = answers_q.pop_front();
          answers_checked++;
          if (want.status == STAT_FULL) full_seen++;
          if (want.status == STAT_ABSENT) absent_seen++;
          if (seen.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_o);
            errors++;
          end
          if (seen.node !== want.node) begin
            $error("node mismatch: expected %0d, got %0d", want.node, node_o);
            errors++;
          end
        end
      end
    end
  end

  // hard stop
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(action_e a, logic [7:0] s, logic l, logic e);
    letters_q.push_back(letter_item_t'{act: a, sym: s, last: l, is_empty: e});
    items_queued++;
  endtask

  // Queue wbuf as one word; mixed gives each letter but the last a random action.
  task automatic queue_word(action_e a, bit mixed);
    action_e act;
    if (wlen == 0) begin
      queue_item(a, 8'($urandom_range(1, 255)), 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < wlen; i++) begin
        act = (mixed && i < wlen - 1) ? action_e'($urandom_range(0, 1)) : a;
        queue_item(act, wbuf[i], i == wlen - 1, 1'b0);
      end
    end
  endtask

  // small alphabet makes words share prefixes and chains
  function automatic logic [7:0] rand_letter(bit wide);
    return wide ? 8'($urandom_range(1, 255)) : 8'($urandom_range(97, 104));
  endfunction

  task automatic rand_word(int len, bit wide);
    wlen = len;
    for (int i = 0; i < len; i++) wbuf[i] = rand_letter(wide);
  endtask

  task automatic pick_known();
    int k;
    if (dict_count == 0) begin
      rand_word($urandom_range(1, 4), 1'b0);
    end else begin
      k = $urandom_range(0, dict_count - 1);
      wlen = dict_len[k];
      for (int i = 0; i < wlen; i++) wbuf[i] = dict_sym[k][i];
    end
  endtask

  task automatic remember_word();
    int k;
    if (dict_count < DictDepth) begin
      k = dict_count;
      dict_count++;
    end else begin
      k = $urandom_range(0, DictDepth - 1);
    end
    dict_len[k] = wlen;
    for (int i = 0; i < wlen; i++) dict_sym[k][i] = wbuf[i];
  endtask

  // Mostly well-formed words: inserts, lookups of known words, prefixes and
  // extensions, repeats; the rest empty words, mixed words and loose noise.
  task automatic queue_random(int count);
    int stop;
    int sel;
    stop = items_queued + count;
    while (items_queued < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        rand_word($urandom_range(1, 5), $urandom_range(0, 5) == 0);
        queue_word(ACT_INSERT, 1'b0);
        remember_word();
      end else if (sel < 46) begin
        pick_known();
        queue_word(ACT_LOOKUP, 1'b0);
      end else if (sel < 56) begin
        pick_known();
        if ($urandom_range(0, 1) && wlen > 1) begin
          wlen--;
        end else if (wlen < MaxWordLen) begin
          wbuf[wlen] = rand_letter(1'b0);
          wlen++;
        end
        queue_word(ACT_LOOKUP, 1'b0);
      end else if (sel < 63) begin
        pick_known();
        queue_word(ACT_INSERT, 1'b0);
      end else if (sel < 72) begin
        rand_word($urandom_range(1, 4), 1'b0);
        queue_word(ACT_LOOKUP, 1'b0);
      end else if (sel < 77) begin
        queue_item(action_e'($urandom_range(0, 1)), 8'($urandom_range(1, 255)),
                   1'($urandom_range(0, 1)), 1'b1);
      end else if (sel < 85) begin
        pick_known();
        queue_word(action_e'($urandom_range(0, 1)), 1'b1);
      end else if (sel < 93) begin
        queue_item(action_e'($urandom_range(0, 1)), 8'($urandom_range(1, 255)),
                   1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      end else begin
        rand_word($urandom_range(1, 3), 1'b1);
        queue_word(ACT_INSERT, 1'b0);
        remember_word();
      end
    end
  endtask

  // Wait until every queued item went in and every answer came out.
  task automatic wait_drained();
    while (letters_q.size() > 0 || answers_q.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  // Write node_limit over APB, then read it back.
  task automatic set_node_limit(int value);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegNodeLimit, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    limit_reg = value & 'h7FF;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(limit_reg)) begin
      $error("node_limit readback mismatch: expected %0d, got %0d", limit_reg, rd);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence. Node allocation never rolls back, so the tight limits come
  // first while the trie is still empty.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_INSERT;
    letter_i     = 8'd1;
    last_i       = 1'b0;
    empty_word_i = 1'b0;
    out_ready_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    trie_nodes   = 1;
    cursor       = 0;
    word_err     = STAT_TAKEN;
    limit_reg    = MaxNodes;
    for (int i = 0; i < MaxNodes; i++) trie_final[i] = 1'b0;
    for (int i = 0; i < HashBuckets; i++) chain_head[i] = 0;
    send_odds = 20;
    recv_odds = 10;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // limit below 2: nothing can be allocated
    set_node_limit(1);
    queue_item(ACT_INSERT, 8'd97, 1'b1, 1'b0);    // full at once
    queue_item(ACT_INSERT, 8'd255, 1'b0, 1'b1);   // empty word, last low: root final
    queue_item(ACT_LOOKUP, 8'd1, 1'b1, 1'b1);     // empty word found
    queue_item(ACT_INSERT, 8'd120, 1'b0, 1'b0);   // full ...
    queue_item(ACT_INSERT, 8'd121, 1'b1, 1'b0);   // ... and stays full to the end
    queue_item(ACT_LOOKUP, 8'd97, 1'b1, 1'b0);    // absent
    wait_drained();

    // room for exactly one node
    set_node_limit(2);
    queue_item(ACT_INSERT, 8'd255, 1'b1, 1'b0);   // node 1
    queue_item(ACT_INSERT, 8'd1, 1'b1, 1'b0);     // full
    queue_item(ACT_LOOKUP, 8'd255, 1'b1, 1'b0);   // found
    queue_item(ACT_LOOKUP, 8'd255, 1'b0, 1'b0);
    queue_item(ACT_LOOKUP, 8'd1, 1'b1, 1'b0);     // absent past node 1
    queue_item(ACT_INSERT, 8'd255, 1'b0, 1'b0);
    queue_item(ACT_INSERT, 8'd7, 1'b1, 1'b0);     // full after a taken letter
    queue_item(ACT_INSERT, 8'd255, 1'b0, 1'b0);
    queue_item(ACT_LOOKUP, 8'd9, 1'b0, 1'b1);     // empty mid-word, judged at node 1
    wait_drained();

    // above the node count: acts as the full table; mixed-action words
    set_node_limit(2047);
    queue_item(ACT_INSERT, 8'd3, 1'b0, 1'b0);
    queue_item(ACT_LOOKUP, 8'd4, 1'b1, 1'b0);     // insert then lookup miss
    queue_item(ACT_LOOKUP, 8'd255, 1'b0, 1'b0);
    queue_item(ACT_INSERT, 8'd128, 1'b1, 1'b0);   // lookup then insert: allocates
    queue_item(ACT_LOOKUP, 8'd255, 1'b0, 1'b0);
    queue_item(ACT_LOOKUP, 8'd128, 1'b1, 1'b0);   // found
    queue_item(ACT_LOOKUP, 8'd3, 1'b1, 1'b0);     // node exists, not final
    queue_random(150);
    stall_asked++;
    wait_drained();

    // a few nodes of headroom, so the table fills mid-phase
    set_node_limit(trie_nodes + 12);
    send_odds = 35;
    recv_odds = 25;
    queue_random(150);
    wait_drained();

    // full size, no idling to the end
    set_node_limit(MaxNodes);
    send_odds = 0;
    recv_odds = 0;
    queue_random(150);
    wait_drained();

    repeat (DrainWait) @(posedge clk_i);
    if (answers_q.size() > 0) begin
      $error("%0d answers never arrived", answers_q.size());
      errors++;
    end
    $display("summary: %0d letter items, %0d answers checked, %0d nodes in the trie",
             items_queued, answers_checked, trie_nodes);
    $display("summary: %0d table-full and %0d absent answers across five node limits",
             full_seen, absent_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
